FILE: rtl/gbb_pkg.sv
// ----------------------------------------------------------------------------
// gbb_pkg
// Shared types, codes and helper functions of the grayscale bitmap blitter.
// ----------------------------------------------------------------------------
package gbb_pkg;

    // Operation codes carried in the input word's tuser bits.
    localparam logic [1:0] OP_FILL  = 2'd0;
    localparam logic [1:0] OP_IMAGE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y     = 3'd1;
    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd2;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd3;
    localparam logic [2:0] REG_DEPTH_SELECT = 3'd4;

    // Widest image the blitter walks; larger widths are clamped to it.
    localparam logic [10:0] MAX_WIDTH = 11'd1024;

    // Depth of the command queue between front and back (power of two).
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        CMD_FILL,
        CMD_IMAGE,
        CMD_READ
    } cmd_kind_t;

    typedef enum logic [2:0] {
        BK_SWEEP,
        BK_IDLE,
        BK_ROW,
        BK_SCAN,
        BK_WRITE,
        BK_READ,
        BK_RESULT
    } bk_state_t;

    typedef struct packed {
        logic signed [10:0] origin_x;
        logic signed [10:0] origin_y;
        logic [10:0]        image_width;
        logic [10:0]        image_height;
        logic [1:0]         depth_select;
    } cfg_t;

    // One unit of work for the back end.
    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  data;   // source byte, or fill gray in the low nibble
        logic [10:0] row;    // source row of an image byte
        logic [12:0] px0;    // first source pixel index of an image byte
        logic [12:0] addr;   // byte address of a read
    } cmd_t;

    // Image width clamped to the widest supported image.
    function automatic logic [10:0] gbb_width_eff(input logic [10:0] w);
        return (w > MAX_WIDTH) ? MAX_WIDTH : w;
    endfunction

    // Scale one source pixel to a 4-bit gray level. The 8 bpp case divides
    // by 17 through a multiply by 241 and a shift by 12, exact for 0..255.
    function automatic logic [3:0] gbb_scale(input logic [7:0] v, input logic [1:0] depth);
        logic [15:0] prod;
        logic [3:0]  g;
        prod = 16'(v) * 16'd241;
        case (depth)
            2'd0:    g = v[0] ? 4'hF : 4'h0;
            2'd1:    g = 4'({2'b00, v[1:0]} * 4'd5);
            2'd2:    g = v[3:0];
            2'd3:    g = prod[15:12];
            default: g = 4'h0;
        endcase
        return g;
    endfunction

endpackage

FILE: rtl/gbb_queue.sv
// ----------------------------------------------------------------------------
// gbb_queue
// Small command FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module gbb_queue
    import gbb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic empty,
    output cmd_t pop_cmd
);

    cmd_t              entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              do_push;
    logic              do_pop;

    // Status and head of the queue.
    assign full    = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = entries_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Pointer and count updates; the depth is a power of two so pointers wrap.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: rtl/gbb_front.sv
// ----------------------------------------------------------------------------
// gbb_front
// Input side: configuration registers, input word decode and image cursor.
// ----------------------------------------------------------------------------
module gbb_front
    import gbb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [10:0] cfg_data,
    output cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [7:0]  data_byte,
    input  logic        image_start,
    input  logic [12:0] read_address,
    input  logic        init_busy,
    input  logic        q_full,
    output logic        push,
    output cmd_t        push_cmd
);

    cfg_t        cfg_reg;
    logic [9:0]  col_reg;
    logic [9:0]  col_next;
    logic [10:0] row_reg;
    logic [10:0] row_next;
    logic        accept;
    logic [9:0]  col_cur;
    logic [10:0] row_cur;
    logic        img_live;
    logic [1:0]  ppb_log;
    logic [2:0]  ppb_m1;
    logic [10:0] w_eff;
    logic [11:0] cols_raw;
    logic [11:0] cols;
    logic        row_wrap;

    assign cfg      = cfg_reg;
    assign in_ready = !q_full && !init_busy;
    assign accept   = in_valid && in_ready;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x     <= '0;
            cfg_reg.origin_y     <= '0;
            cfg_reg.image_width  <= 11'd1;
            cfg_reg.image_height <= 11'd1;
            cfg_reg.depth_select <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ORIGIN_X:     cfg_reg.origin_x     <= cfg_data;
                REG_ORIGIN_Y:     cfg_reg.origin_y     <= cfg_data;
                REG_IMAGE_WIDTH:  cfg_reg.image_width  <= cfg_data;
                REG_IMAGE_HEIGHT: cfg_reg.image_height <= cfg_data;
                REG_DEPTH_SELECT: cfg_reg.depth_select <= cfg_data[1:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // Source bytes per row: clamped width over pixels per byte, rounded up,
    // and never below one.
    always_comb
    begin
        ppb_log  = 2'd3 - cfg_reg.depth_select;
        ppb_m1   = 3'b111 >> cfg_reg.depth_select;
        w_eff    = gbb_width_eff(cfg_reg.image_width);
        cols_raw = ({1'b0, w_eff} + {9'b0, ppb_m1}) >> ppb_log;
        cols     = (cols_raw == '0) ? 12'd1 : cols_raw;
    end

    // Cursor seen by this byte: the start flag moves it back to the origin.
    always_comb
    begin
        col_cur  = image_start ? '0 : col_reg;
        row_cur  = image_start ? '0 : row_reg;
        img_live = (row_cur < cfg_reg.image_height);
        row_wrap = (({2'b0, col_cur} + 12'd1) >= cols);
    end

    // Classify the word and build the back end's command.
    always_comb
    begin
        push_cmd.data = data_byte;
        push_cmd.row  = row_cur;
        push_cmd.px0  = {3'b0, col_cur} << ppb_log;
        push_cmd.addr = read_address;
        push_cmd.kind = CMD_READ;
        push          = 1'b0;
        case (operation)
            OP_FILL:
            begin
                push_cmd.kind = CMD_FILL;
                push          = accept;
            end
            OP_IMAGE:
            begin
                push_cmd.kind = CMD_IMAGE;
                push          = accept && img_live;
            end
            OP_READ:
            begin
                push_cmd.kind = CMD_READ;
                push          = accept;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    // Cursor advance: next byte of the row, or the start of the next row.
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept && (operation == OP_IMAGE))
        begin
            col_next = col_cur;
            row_next = row_cur;
            if (img_live)
            begin
                if (row_wrap)
                begin
                    col_next = '0;
                    row_next = row_cur + 11'd1;
                end
                else
                begin
                    col_next = col_cur + 10'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

FILE: rtl/gbb_back.sv
// ----------------------------------------------------------------------------
// gbb_back
// Execution side: frame memory, fill sweep, pixel read-modify-write and reads.
// ----------------------------------------------------------------------------
module gbb_back
    import gbb_pkg::*;
#(
    parameter int SCREEN_COLUMNS = 256,
    parameter int SCREEN_ROWS    = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       q_empty,
    input  cmd_t       q_cmd,
    output logic       q_pop,
    output logic       init_busy,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_data
);

    localparam int BYTES_PER_ROW = (SCREEN_COLUMNS + 1) / 2;
    localparam int STORE_BYTES   = BYTES_PER_ROW * SCREEN_ROWS;
    localparam int ADDR_W        = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

    logic [7:0]        mem [STORE_BYTES];
    logic [7:0]        rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    bk_state_t         state_reg;
    bk_state_t         state_next;
    logic              init_reg;
    logic [ADDR_W-1:0] sweep_reg;
    logic [7:0]        fill_reg;
    logic              out_valid_reg;
    logic [7:0]        out_data_reg;
    cmd_t              cmd_reg;
    logic [ADDR_W-1:0] row_base_reg;
    logic              y_ok_reg;
    logic [2:0]        idx_reg;
    logic [7:0]        sh_reg;
    logic [ADDR_W-1:0] wr_addr_reg;
    logic              odd_reg;
    logic [3:0]        gray_reg;
    logic              rd_ok_reg;

    logic [12:0]       y_s;
    logic              y_ok;
    logic [31:0]       row_prod;
    logic [12:0]       px;
    logic [7:0]        pix_v;
    logic [3:0]        gray;
    logic [14:0]       x_s;
    logic              x_ok;
    logic              vis;
    logic              last_pix;
    logic [31:0]       pix_addr32;
    logic [31:0]       rd_addr32;
    logic              rd_ok;
    logic              load_out;
    logic [7:0]        sh_adv;

    assign init_busy = init_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Row of the current image byte on screen, and its first byte address.
    always_comb
    begin
        y_s      = {{2{cfg.origin_y[10]}}, cfg.origin_y} + {2'b0, cmd_reg.row};
        y_ok     = !y_s[12] && ({19'b0, y_s} < 32'(SCREEN_ROWS));
        row_prod = {20'b0, y_s[11:0]} * 32'(BYTES_PER_ROW);
    end

    // Current pixel of the byte: its value, gray level and screen position.
    always_comb
    begin
        px = cmd_reg.px0 + {10'b0, idx_reg};
        case (cfg.depth_select)
            2'd0:    pix_v = {7'b0, sh_reg[7]};
            2'd1:    pix_v = {6'b0, sh_reg[7:6]};
            2'd2:    pix_v = {4'b0, sh_reg[7:4]};
            default: pix_v = sh_reg;
        endcase
        case (cfg.depth_select)
            2'd0:    sh_adv = {sh_reg[6:0], 1'b0};
            2'd1:    sh_adv = {sh_reg[5:0], 2'b0};
            2'd2:    sh_adv = {sh_reg[3:0], 4'b0};
            default: sh_adv = 8'h00;
        endcase
        gray       = gbb_scale(pix_v, cfg.depth_select);
        x_s        = {{4{cfg.origin_x[10]}}, cfg.origin_x} + {2'b0, px};
        x_ok       = !x_s[14] && ({17'b0, x_s} < 32'(SCREEN_COLUMNS));
        vis        = y_ok_reg && x_ok && (gray != 4'h0)
                     && (px < {2'b0, gbb_width_eff(cfg.image_width)});
        last_pix   = (idx_reg == (3'b111 >> cfg.depth_select));
        pix_addr32 = 32'(row_base_reg) + {18'b0, x_s[14:1]};
    end

    // Read request range check.
    always_comb
    begin
        rd_addr32 = {19'b0, cmd_reg.addr};
        rd_ok     = (rd_addr32 < 32'(STORE_BYTES));
        load_out  = (state_reg == BK_RESULT) && (!out_valid_reg || out_ready);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_SWEEP:
            begin
                if (sweep_reg == LAST_ADDR)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    case (q_cmd.kind)
                        CMD_FILL:  state_next = BK_SWEEP;
                        CMD_IMAGE: state_next = BK_ROW;
                        CMD_READ:  state_next = BK_READ;
                        default:   state_next = BK_IDLE;
                    endcase
                end
            end
            BK_ROW:
            begin
                state_next = BK_SCAN;
            end
            BK_SCAN:
            begin
                if (vis)
                begin
                    state_next = BK_WRITE;
                end
                else if (last_pix)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_WRITE:
            begin
                state_next = last_pix ? BK_IDLE : BK_SCAN;
            end
            BK_READ:
            begin
                state_next = BK_RESULT;
            end
            BK_RESULT:
            begin
                if (load_out)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Memory port and queue controls for each state.
    always_comb
    begin
        q_pop     = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = sweep_reg;
        mem_wdata = fill_reg;
        mem_re    = 1'b0;
        mem_raddr = pix_addr32[ADDR_W-1:0];
        case (state_reg)
            BK_SWEEP:
            begin
                mem_we = 1'b1;
            end
            BK_IDLE:
            begin
                q_pop = !q_empty;
            end
            BK_SCAN:
            begin
                mem_re = vis;
            end
            BK_WRITE:
            begin
                mem_we    = 1'b1;
                mem_waddr = wr_addr_reg;
                mem_wdata = odd_reg ? {rdata_reg[7:4], gray_reg}
                                    : {gray_reg, rdata_reg[3:0]};
            end
            BK_READ:
            begin
                mem_re    = rd_ok;
                mem_raddr = rd_addr32[ADDR_W-1:0];
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_SWEEP;
            init_reg      <= 1'b1;
            sweep_reg     <= '0;
            fill_reg      <= 8'h00;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BK_SWEEP)
            begin
                sweep_reg <= sweep_reg + 1'b1;
                if (sweep_reg == LAST_ADDR)
                begin
                    init_reg <= 1'b0;
                end
            end
            if (q_pop && (q_cmd.kind == CMD_FILL))
            begin
                sweep_reg <= '0;
                fill_reg  <= {q_cmd.data[3:0], q_cmd.data[3:0]};
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_cmd;
        end
        if (state_reg == BK_ROW)
        begin
            row_base_reg <= row_prod[ADDR_W-1:0];
            y_ok_reg     <= y_ok;
            idx_reg      <= '0;
            sh_reg       <= cmd_reg.data;
        end
        if ((state_reg == BK_SCAN) && vis)
        begin
            wr_addr_reg <= pix_addr32[ADDR_W-1:0];
            odd_reg     <= x_s[0];
            gray_reg    <= gray;
        end
        if (((state_reg == BK_SCAN) && !vis) || (state_reg == BK_WRITE))
        begin
            idx_reg <= idx_reg + 3'd1;
            sh_reg  <= sh_adv;
        end
        if (state_reg == BK_READ)
        begin
            rd_ok_reg <= rd_ok;
        end
        if (load_out)
        begin
            out_data_reg <= rd_ok_reg ? rdata_reg : 8'h00;
        end
    end

    // Frame memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // The single memory port is never asked to read and write at once.
    assert property (@(posedge clk) disable iff (!rst_n) !(mem_we && mem_re))
        else $error("frame memory read and write in the same cycle");

    // A pixel write always follows the read of the same byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_WRITE) |-> ($past(state_reg) == BK_SCAN) && $past(mem_re))
        else $error("pixel write without a preceding read");

    // No command leaves the queue while the memory is being cleared.
    assert property (@(posedge clk) disable iff (!rst_n) init_reg |-> !q_pop)
        else $error("command taken during the clearing pass");

    // A pending read result is loaded into an empty result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == BK_RESULT) && !out_valid_reg) |=> out_valid_reg)
        else $error("read result not delivered to the output register");

    // The sweep address steps by one until the sweep ends.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == BK_SWEEP) && (sweep_reg != LAST_ADDR))
        |=> (sweep_reg == ADDR_W'($past(sweep_reg) + 1'b1)))
        else $error("sweep address skipped");

endmodule

FILE: rtl/gray_bitmap_blitter_4bpp.sv
// ----------------------------------------------------------------------------
// gray_bitmap_blitter_4bpp
// 4-bit grayscale framebuffer with fill, bitmap blit and byte read-back.
// ----------------------------------------------------------------------------
// After reset the block clears the frame memory, one byte per cycle, over all
// ((SCREEN_COLUMNS + 1) / 2) * SCREEN_ROWS bytes (8192 at the default size),
// and holds s_tready low meanwhile. A fill word sweeps the whole memory in
// the same way. An image byte passes through a row setup state, then a scan
// state per source pixel in it and a write state per pixel actually drawn;
// the single-port read-modify-write reads a drawn pixel's byte in the scan
// state and writes it back in the write state. A read word reads its byte
// in the read state and registers it onto m_tdata in the result state.
// Words that draw nothing past the image height take no back-end time. A
// four-deep command queue lets the input keep accepting words while the back
// end works or a result waits on m_tready.
module gray_bitmap_blitter_4bpp
    import gbb_pkg::*;
#(
    parameter int SCREEN_COLUMNS = 256,
    parameter int SCREEN_ROWS    = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [7:0] data_byte, [20:8] read_address
    input  logic [2:0]  s_tuser,    // [1:0] operation, [2] image_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata     // [7:0] read_data
);

    cfg_t cfg;
    logic init_busy;
    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    cmd_t push_cmd;
    cmd_t pop_cmd;

    gbb_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .operation    (s_tuser[1:0]),
        .data_byte    (s_tdata[7:0]),
        .image_start  (s_tuser[2]),
        .read_address (s_tdata[20:8]),
        .init_busy    (init_busy),
        .q_full       (q_full),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    gbb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .pop_cmd  (pop_cmd)
    );

    gbb_back #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_ROWS    (SCREEN_ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_empty   (q_empty),
        .q_cmd     (pop_cmd),
        .q_pop     (pop),
        .init_busy (init_busy),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule
